// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, sampled on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every edge.
`define DXTU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DXTU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dxtu_pkg.sv =====
// ----------------------------------------------------------------------------
// DXT to UTX2 transcoder package
// Opcodes, bit masks, selector remap tables and bit helpers.
// ----------------------------------------------------------------------------
package dxtu_pkg;

   localparam logic [1:0] OP_DXT1_PUNCH  = 2'd0;
   localparam logic [1:0] OP_DXT1_OPAQUE = 2'd1;
   localparam logic [1:0] OP_DXT5        = 2'd2;

   localparam logic [15:0] MASK_555_HI   = 16'h7FE0;
   localparam logic [15:0] MASK_555_LO   = 16'h001F;
   localparam logic [15:0] MASK_LOW_BITS = 16'h0421;
   localparam logic [15:0] FLAG_ALPHA    = 16'h8000;
   localparam logic [7:0]  ALPHA_LIMIT   = 8'd224;

   // nibble k holds the new selector for DXT selector k
   localparam logic [15:0] REMAP_NORMAL = 16'h1203;
   localparam logic [15:0] REMAP_PUNCH  = 16'h1002;
   localparam logic [15:0] REMAP_DXT5A  = 16'h0202;

   localparam int unsigned NUM_PIXELS = 16;

   typedef struct packed {
      logic punch;   // DXT1 punch-through alpha block
      logic dxt5a;   // DXT5 block with alpha in effect
   } dxtu_mode_type;

   function automatic logic [15:0] dxtu_to555(input logic [15:0] c565);
      dxtu_to555 = ({1'b0, c565[15:1]} & MASK_555_HI) | (c565 & MASK_555_LO);
   endfunction

   function automatic logic [15:0] dxtu_alpha_bits(input logic [7:0] a);
      dxtu_alpha_bits = {5'b0, a[7], 4'b0, a[6], 4'b0, a[5]};
   endfunction

   // raster pixel p = 4*y + x  ->  x0 | y0<<1 | x1<<2 | y1<<3
   function automatic logic [3:0] dxtu_morton(input logic [3:0] p);
      dxtu_morton = {p[3], p[1], p[2], p[0]};
   endfunction

   function automatic logic [1:0] dxtu_remap(input logic [15:0] tbl, input logic [1:0] s);
      logic [1:0] v;
      case (s)
         2'd0:    v = tbl[1:0];
         2'd1:    v = tbl[5:4];
         2'd2:    v = tbl[9:8];
         default: v = tbl[13:12];
      endcase
      dxtu_remap = v;
   endfunction

endpackage

// ===== hdl/dxtu_endpoint.sv =====
// ----------------------------------------------------------------------------
// DXT to UTX2 endpoint and mode decode
// Narrows both endpoints to RGB555 and applies the alpha block rules.
// ----------------------------------------------------------------------------
module dxtu_endpoint (
   input  logic [1:0]              opcode,
   input  logic [15:0]             color0,
   input  logic [15:0]             color1,
   input  logic [7:0]              alpha0,
   input  logic [7:0]              alpha1,
   output logic [15:0]             endpoint_a,
   output logic [15:0]             endpoint_b,
   output dxtu_pkg::dxtu_mode_type mode
);
   import dxtu_pkg::*;

   logic [15:0] ca;
   logic [15:0] cb;

   assign ca = dxtu_to555(color0);
   assign cb = dxtu_to555(color1);

   always_comb begin
      mode.punch = (opcode == OP_DXT1_PUNCH) && (color0 <= color1);
      mode.dxt5a = (opcode == OP_DXT5) && ((alpha0 < ALPHA_LIMIT) || (alpha1 < ALPHA_LIMIT));
      endpoint_a = ca;
      endpoint_b = cb;
      if (mode.punch) begin
         endpoint_a = ca & ~MASK_LOW_BITS;
         endpoint_b = cb | MASK_LOW_BITS | FLAG_ALPHA;
      end else if (mode.dxt5a) begin
         endpoint_a = (ca & ~MASK_LOW_BITS) | dxtu_alpha_bits(alpha0);
         endpoint_b = (cb & ~MASK_LOW_BITS) | FLAG_ALPHA | dxtu_alpha_bits(alpha1);
      end
   end

endmodule

// ===== hdl/dxtu_lane.sv =====
// ----------------------------------------------------------------------------
// DXT to UTX2 selector lane
// Remaps one pixel's 2-bit selector; DXT5 alpha forces bit 0 on even index.
// ----------------------------------------------------------------------------
module dxtu_lane (
   input  dxtu_pkg::dxtu_mode_type mode,
   input  logic [1:0]              sel_in,
   input  logic [2:0]              alpha_idx,
   output logic [1:0]              sel_out
);
   import dxtu_pkg::*;

   logic [15:0] tbl;

   always_comb begin
      if (mode.punch) begin
         tbl = REMAP_PUNCH;
      end else if (mode.dxt5a) begin
         tbl = REMAP_DXT5A;
      end else begin
         tbl = REMAP_NORMAL;
      end
      sel_out = dxtu_remap(tbl, sel_in);
      if (mode.dxt5a && !alpha_idx[0]) begin
         sel_out[0] = 1'b1;
      end
   end

endmodule

// ===== hdl/dxt_block_to_utx2_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// DXT block to UTX2 transcoder core
// Converts one DXT1/DXT5 4x4 color block per transaction to a UTX2 block.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel carries one block per transaction: opcode (0 DXT1 with
//   punch-through, 1 DXT1 opaque, 2 DXT5, 3 treated as opaque), the 64-bit
//   color block and the 64-bit DXT5 alpha block (ignored unless DXT5).
//   rsp_* channel returns exactly one 64-bit UTX2 block per request, in order.
//   A transaction completes on a rising edge with valid high and stall low.
//   Each accepted block reaches rsp_* through the output register.
//   Throughput: one block per cycle while rsp_stall is low. The conversion
//   is combinational bit remapping: an endpoint decoder plus sixteen
//   selector lanes, merged into Morton order ahead of the output register.
//   Stall: while rsp_stall holds a result, one more request is still taken
//   into a skid register; req_stall rises only once the skid is full.
//   Reset (synchronous, active high) empties the output and skid registers;
//   no block is in flight afterwards.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dxt_block_to_utx2_transcoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_color_block,
   input  logic [63:0] req_alpha_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_utx2_block
);
   import dxtu_pkg::*;

   dxtu_mode_type mode;
   logic [15:0]   endpoint_a;
   logic [15:0]   endpoint_b;
   logic [1:0]    lane_sel [NUM_PIXELS];
   logic [31:0]   morton_sel;
   logic [63:0]   block_new;

   logic          out_valid_ff, out_valid_in;
   logic [63:0]   out_data_ff, out_data_in;
   logic          skid_valid_ff, skid_valid_in;
   logic [63:0]   skid_data_ff, skid_data_in;
   logic          accept;
   logic          out_free;

   // Endpoint narrowing and block mode
   dxtu_endpoint u_endpoint (
      .opcode     (req_opcode),
      .color0     (req_color_block[15:0]),
      .color1     (req_color_block[31:16]),
      .alpha0     (req_alpha_block[7:0]),
      .alpha1     (req_alpha_block[15:8]),
      .endpoint_a (endpoint_a),
      .endpoint_b (endpoint_b),
      .mode       (mode)
   );

   // One lane per pixel; lane outputs land at their Morton slot
   for (genvar p = 0; p < NUM_PIXELS; p++) begin : g_lane
      localparam logic [3:0] Z = dxtu_morton(4'(p));

      dxtu_lane u_lane (
         .mode      (mode),
         .sel_in    (req_color_block[32 + 2*p +: 2]),
         .alpha_idx (req_alpha_block[16 + 3*p +: 3]),
         .sel_out   (lane_sel[p])
      );

      assign morton_sel[2*Z +: 2] = lane_sel[p];
   end

   assign block_new = {morton_sel, endpoint_b, endpoint_a};

   // Output register with one-entry skid
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_valid_in = 1'b1;
            out_data_in  = block_new;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = block_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_utx2_block = out_data_ff;

   // Checks
   `DXTU_ASSERT(a_skid_behind_out, !skid_valid_ff || out_valid_ff,
      "skid holds data while output register is empty")
   `DXTU_ASSERT(a_mode_exclusive, !(mode.punch && mode.dxt5a),
      "punch-through and DXT5 alpha both set")
   `DXTU_ASSERT_NEXT(a_skid_drains, skid_valid_ff && !rsp_stall,
      out_valid_ff && !skid_valid_ff, "skid did not drain into output register")
   `DXTU_ASSERT_NEXT(a_accept_shows, accept, out_valid_ff,
      "accepted transaction produced no response")
   `DXTU_ASSERT_NEXT(a_alpha_flag, accept && out_free,
      rsp_utx2_block[31] == $past(mode.punch || mode.dxt5a),
      "alpha flag does not match block mode")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DXT to UTX2 transcoder testbench
// Streams DXT1/DXT5 blocks through the core with random idle and stall
// bursts, predicts every UTX2 block in-bench and checks each one, in order.
// ----------------------------------------------------------------------------
module testbench;
   import dxtu_pkg::*;

   // opcode 3 has no name in the package; the core treats it as DXT1 opaque
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // selector remap tables, 2 bits per DXT selector, selector 0 in the LSBs
   localparam logic [7:0] SEL_NORMAL = {2'd1, 2'd2, 2'd0, 2'd3};
   localparam logic [7:0] SEL_PUNCH  = {2'd1, 2'd0, 2'd0, 2'd2};
   localparam logic [7:0] SEL_DXT5A  = {2'd0, 2'd2, 2'd0, 2'd2};

   localparam int RANDOM_ITEMS   = 750;
   localparam int TAIL_ITEMS     = 100;   // last stretch runs with no idling
   localparam int HOLDOFF_AT     = 250;   // results taken before the long hold-off
   localparam int HOLDOFF_CYCLES = 40;
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_PRINTS     = 20;
   localparam longint LIMIT_NS   = 3_000_000;

   typedef struct {
      logic [1:0]  opcode;
      logic [63:0] color_block;
      logic [63:0] alpha_block;
   } block_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_DXT1_OPAQUE;
   logic [63:0] req_color_block = '0;
   logic [63:0] req_alpha_block = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_utx2_block;

   block_req_type pending_blocks_q[$];   // blocks not yet offered to the core
   logic [63:0]   expected_utx2_q[$];    // predicted UTX2 blocks, oldest first

   int total_items    = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   int holdoff_left   = 0;
   bit holdoff_done   = 1'b0;
   int rsp_taken      = 0;   // receiver's own count of completed results
   int mismatch_count = 0;
   int blocks_taken   = 0;
   int punch_alpha    = 0;
   int dxt5_alpha     = 0;
   int unused_ops     = 0;
   int req_stall_cycs = 0;

   dxt_block_to_utx2_transcoder_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_color_block (req_color_block),
      .req_alpha_block (req_alpha_block),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_utx2_block  (rsp_utx2_block)
   );

   initial forever #6 clock = ~clock;

   // --------------------------------------------------------------------------
   // UTX2 block predictor
   // --------------------------------------------------------------------------
   function automatic logic [63:0] predict_utx2(input logic [1:0]  op,
                                                input logic [63:0] cblk,
                                                input logic [63:0] ablk);
      logic [15:0] c0, c1, ea, eb;
      logic [7:0]  a0, a1, lut;
      logic        alpha5;
      logic [1:0]  s, v;
      logic [3:0]  pix, z;
      logic [31:0] sel_out;
      int          p;
      c0 = cblk[15:0];
      c1 = cblk[31:16];
      a0 = ablk[7:0];
      a1 = ablk[15:8];
      // RGB565 -> RGB555: drop the low green bit
      ea = {1'b0, c0[15:6], c0[4:0]};
      eb = {1'b0, c1[15:6], c1[4:0]};
      lut = SEL_NORMAL;
      alpha5 = 1'b0;
      if (op == OP_DXT1_PUNCH) begin
         // endpoint0 <= endpoint1 marks a 3-color block with transparent black
         if (c0 <= c1) begin
            ea = ea & ~MASK_LOW_BITS;
            eb = eb | MASK_LOW_BITS | FLAG_ALPHA;
            lut = SEL_PUNCH;
         end
      end else if (op == OP_DXT5) begin
         if (a0 < ALPHA_LIMIT || a1 < ALPHA_LIMIT) begin
            alpha5 = 1'b1;
            ea = ea & ~MASK_LOW_BITS;
            eb = (eb & ~MASK_LOW_BITS) | FLAG_ALPHA;
            // top three alpha bits land on the low bit of each color channel
            ea[10] = a0[7];
            ea[5]  = a0[6];
            ea[0]  = a0[5];
            eb[10] = a1[7];
            eb[5]  = a1[6];
            eb[0]  = a1[5];
            lut = SEL_DXT5A;
         end
      end
      sel_out = '0;
      for (p = 0; p < 16; p++) begin
         pix = p[3:0];
         s = cblk[32 + 2*p +: 2];
         v = lut[2*s +: 2];
         // even alpha index forces selector bit 0
         if (alpha5 && !ablk[16 + 3*p])
            v[0] = 1'b1;
         // raster (y, x) -> Morton {y1, x1, y0, x0}
         z = {pix[3], pix[1], pix[2], pix[0]};
         sel_out[2*z +: 2] = v;
      end
      return {sel_out, eb, ea};
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task automatic add_block(input logic [1:0] op, input logic [63:0] cblk,
                            input logic [63:0] ablk);
      block_req_type item;
      item.opcode      = op;
      item.color_block = cblk;
      item.alpha_block = ablk;
      pending_blocks_q.push_back(item);
   endtask

   // --------------------------------------------------------------------------
   // Driver: offers queued blocks; a stalled transaction stays put until taken
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      logic          holding;
      logic          next_valid;
      bit            idle_ok;
      block_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         holding = req_valid && req_stall;
         next_valid = req_valid;
         // idle in some stretches only, and never near the end of the run
         idle_ok = pending_blocks_q.size() > TAIL_ITEMS &&
                   ((pending_blocks_q.size() / 90) % 3 != 0);
         if (!holding) begin
            if (send_gap != 0) begin
               send_gap--;
               next_valid = 1'b0;
            end else if (idle_ok && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 11);   // start an idle burst
               next_valid = 1'b0;
            end else if (pending_blocks_q.size() != 0) begin
               item = pending_blocks_q.pop_front();
               req_opcode      <= item.opcode;
               req_color_block <= item.color_block;
               req_alpha_block <= item.alpha_block;
               next_valid = 1'b1;
            end else begin
               next_valid = 1'b0;
            end
         end
         req_valid <= next_valid;
      end
   end

   // --------------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off that backs the
   // core up until it stalls its input
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      logic hold_now;
      bit   idle_ok;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            rsp_taken++;
         idle_ok = (rsp_taken + TAIL_ITEMS < total_items) && ((rsp_taken / 70) % 3 != 1);
         hold_now = 1'b0;
         if (holdoff_left != 0) begin
            holdoff_left--;
            hold_now = 1'b1;
         end else if (!holdoff_done && rsp_taken >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES - 1;
            hold_now = 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            hold_now = 1'b1;
         end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            hold_now = 1'b1;
         end
         rsp_stall <= hold_now;
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: predicts on each accepted request before checking the result
   // taken at the same edge, so even a combinational path would line up
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic [63:0] want;
      if (!reset) begin
         if (req_valid && req_stall)
            req_stall_cycs++;
         if (req_valid && !req_stall) begin
            want = predict_utx2(req_opcode, req_color_block, req_alpha_block);
            expected_utx2_q.push_back(want);
            blocks_taken++;
            // bit 31 is the alpha flag of endpoint B
            if (want[31] && req_opcode == OP_DXT1_PUNCH)
               punch_alpha++;
            if (want[31] && req_opcode == OP_DXT5)
               dxt5_alpha++;
            if (req_opcode == OP_UNUSED)
               unused_ops++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_utx2_q.size() == 0) begin
               report_mismatch($sformatf("unexpected utx2_block %h", rsp_utx2_block));
            end else begin
               want = expected_utx2_q.pop_front();
               if (rsp_utx2_block !== want)
                  report_mismatch($sformatf("utx2_block expected %h, got %h",
                                            want, rsp_utx2_block));
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin : stimulus
      logic [63:0] cblk, ablk;
      logic [1:0]  op;
      int          pick;
      int          i;
      // directed: endpoint order around equality in punch-through mode
      add_block(OP_DXT1_PUNCH, 64'hE4E4E4E4_0000_0000, 64'h0);
      add_block(OP_DXT1_PUNCH, 64'h1B1B1B1B_1235_1234, 64'h0);
      add_block(OP_DXT1_PUNCH, 64'hE4E4E4E4_0000_FFFF, 64'h0);
      add_block(OP_DXT1_PUNCH, 64'hFFFFFFFF_FFFF_FFFF, 64'hFFFFFFFF_FFFFFFFF);
      add_block(OP_DXT1_PUNCH, 64'h00000000_FFFF_0000, 64'h0);
      // opaque ignores endpoint order and the alpha block
      add_block(OP_DXT1_OPAQUE, 64'h1B1B1B1B_FFFE_0001, 64'hFFFFFFFF_FFFFFFFF);
      add_block(OP_DXT1_OPAQUE, 64'hFFFFFFFF_FFFF_FFFF, 64'h0);
      add_block(OP_DXT1_OPAQUE, 64'h00000000_0000_0000, 64'h0);
      add_block(OP_UNUSED, 64'hE4E4E4E4_0020_0010, 64'h0);
      add_block(OP_UNUSED, 64'hFFFFFFFF_FFFF_FFFF, 64'hFFFFFFFF_FFFFFFFF);
      // DXT5: alpha limit boundary on either endpoint
      add_block(OP_DXT5, 64'hE4E4E4E4_F81F_07E0, 64'hFAC688FAC688_FFFF);
      add_block(OP_DXT5, 64'hE4E4E4E4_F81F_07E0, 64'hFAC688FAC688_E0E0);
      add_block(OP_DXT5, 64'hE4E4E4E4_1234_ABCD, 64'hFAC688FAC688_FFDF);
      add_block(OP_DXT5, 64'hE4E4E4E4_1234_ABCD, 64'hFAC688FAC688_DFFF);
      // all alpha indices even, then all odd
      add_block(OP_DXT5, 64'h1B1B1B1B_FFFF_0000, 64'h000000000000_0000);
      add_block(OP_DXT5, 64'hE4E4E4E4_FFFF_0000, 64'hFFFFFFFFFFFF_40A0);
      add_block(OP_DXT5, 64'hFFFFFFFF_FFFF_FFFF, 64'hFAC688FAC688_C020);
      add_block(OP_DXT5, 64'h00000000_0000_0000, 64'h0);
      add_block(OP_DXT5, 64'hFFFFFFFF_FFFF_FFFF, 64'hFFFFFFFF_FFFFFFFF);
      add_block(OP_DXT5, 64'h55AA55AA_AAAA_5555, 64'h123456789ABC_00FF);

      // random: mostly DXT5 and punch-through, endpoints often near the
      // decision points so both sides of each comparison are hit
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 9);
         op = (pick < 3) ? OP_DXT1_PUNCH :
              (pick < 5) ? OP_DXT1_OPAQUE :
              (pick < 9) ? OP_DXT5 : OP_UNUSED;
         cblk = {$urandom, $urandom};
         ablk = {$urandom, $urandom};
         if ($urandom_range(0, 4) == 0)
            cblk[31:16] = cblk[15:0];
         else if ($urandom_range(0, 3) == 0)
            cblk[31:16] = cblk[15:0] + 16'd1;
         case ($urandom_range(0, 2))
            0: ablk[7:0] = 8'($urandom_range(218, 229));
            1: ablk[7:0] = 8'($urandom_range(224, 255));
            default: ;
         endcase
         case ($urandom_range(0, 2))
            0: ablk[15:8] = 8'($urandom_range(218, 229));
            1: ablk[15:8] = 8'($urandom_range(224, 255));
            default: ;
         endcase
         add_block(op, cblk, ablk);
      end
      total_items = pending_blocks_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sample away from the active edge so the queues are settled
      do @(negedge clock);
      while (pending_blocks_q.size() != 0 || req_valid || expected_utx2_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d blocks: %0d punch-through alpha, %0d DXT5 alpha, %0d unused opcode",
               blocks_taken, punch_alpha, dxt5_alpha, unused_ops);
      $display("Input held off for %0d cycles; %0d mismatches", req_stall_cycs, mismatch_count);
      if (mismatch_count == 0 && expected_utx2_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("Timeout: %0d results still outstanding", expected_utx2_q.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
